// ===== rtl/texture_tile_format_converter_top_assert.svh =====
// assertion macros shared by the tiled texture converter modules
// no dependencies; each macro expects a clock and an active-high reset
`ifndef TEXTURE_TILE_FORMAT_CONVERTER_TOP_ASSERT_SVH
`define TEXTURE_TILE_FORMAT_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define TTFC_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttfc: same-cycle check failed");

// next-cycle implication
`define TTFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttfc: next-cycle check failed");

`endif

// ===== rtl/ttfc_pkg.sv =====
// shared types and constants of the tiled texture converter
// no dependencies; imported by every module of the block
`default_nettype none

package ttfc_pkg;

   // size limits and fixed widths
   localparam int TTFC_MAX_SIDE    = 1024;
   localparam int TTFC_TILE_BYTES  = 32;
   localparam int TTFC_CSR_W       = 11;
   localparam int TTFC_CSR_IDX_W   = 2;
   localparam int TTFC_OFFSET_W    = 21;
   localparam int TTFC_INNER_W     = 5;
   localparam int TTFC_QUEUE_DEPTH = 2;

   localparam logic [TTFC_CSR_W-1:0] TTFC_SIDE_RESET = 11'd1024;

   // register indexes
   localparam logic [TTFC_CSR_IDX_W-1:0] CSR_FORMAT = 2'd0;
   localparam logic [TTFC_CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [TTFC_CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   // texel formats
   typedef enum logic [1:0] {
      FMT_I4     = 2'd0,
      FMT_IA4    = 2'd1,
      FMT_RGB565 = 2'd2,
      FMT_RGB5A3 = 2'd3
   } fmt_type;

   // write part codes
   typedef enum logic [1:0] {
      PART_WORD        = 2'd0,
      PART_BYTE        = 2'd1,
      PART_HIGH_NIBBLE = 2'd2,
      PART_LOW_NIBBLE  = 2'd3
   } part_type;

   // input pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   // tiled write
   typedef struct packed {
      logic [TTFC_OFFSET_W-1:0] byte_offset;
      logic [15:0]              write_data;
      logic [1:0]               write_part;
      logic                     last_pixel;
   } rsp_type;

   // fixed-width part of a classified pixel
   typedef struct packed {
      fmt_type                 fmt;
      req_type                 pixel;
      logic                    odd_column;
      logic [TTFC_INNER_W-1:0] inner;
      logic                    last;
   } desc_type;

endpackage

`default_nettype wire

// ===== rtl/ttfc_front.sv =====
// front end: configuration registers, pixel counters and tile classification
// depends on ttfc_pkg
`default_nettype none

module ttfc_front
   import ttfc_pkg::*;
#(
   parameter int MAX_SIDE = TTFC_MAX_SIDE,
   localparam int CNT_W    = $clog2(MAX_SIDE),
   localparam int SIDE_W   = $clog2(MAX_SIDE + 1),
   localparam int TCOORD_W = $clog2((MAX_SIDE - 1) / 4 + 1),
   localparam int TPR_W    = $clog2((MAX_SIDE + 3) / 4 + 1)
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_write_en,
   input  wire  [TTFC_CSR_IDX_W-1:0] csr_index,
   input  wire  [TTFC_CSR_W-1:0]     csr_write_data,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   input  wire                       q_full,
   output logic                      q_push,
   output desc_type                  desc,
   output logic [TCOORD_W-1:0]       tile_row,
   output logic [TCOORD_W-1:0]       tile_col,
   output logic [TPR_W-1:0]          tiles_per_row
);

   // zero acts as one, oversize acts as the maximum
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [TTFC_CSR_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (32'(v) > MAX_SIDE) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = SIDE_W'(v);
      end
      return r;
   endfunction

   fmt_type           fmt_ff, fmt_in;
   logic [SIDE_W-1:0] width_ff, width_in;
   logic [SIDE_W-1:0] height_ff, height_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;

   logic              accept;
   logic              col_end;
   logic              row_end;
   logic              img_end;
   logic [SIDE_W:0]   tpr_sum;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // configuration writes, stored already clamped
   always_comb begin
      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FORMAT: fmt_in    = fmt_type'(csr_write_data[1:0]);
            CSR_WIDTH:  width_in  = clamp_side(csr_write_data);
            CSR_HEIGHT: height_in = clamp_side(csr_write_data);
            default: ;
         endcase
      end
   end

   // end of row and end of image
   assign col_end = (SIDE_W'(col_ff) + SIDE_W'(1)) >= width_ff;
   assign row_end = (SIDE_W'(row_ff) + SIDE_W'(1)) >= height_ff;
   assign img_end = col_end && row_end;

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   // tile geometry for the current format
   always_comb begin
      desc.fmt        = fmt_ff;
      desc.pixel      = req_data;
      desc.odd_column = col_ff[0];
      desc.last       = img_end;
      case (fmt_ff)
         FMT_I4: begin
            desc.inner = {row_ff[2:0], col_ff[2:1]};
            tile_row   = TCOORD_W'(row_ff >> 3);
            tile_col   = TCOORD_W'(col_ff >> 3);
            tpr_sum    = {1'b0, width_ff} + (SIDE_W + 1)'(7);
         end
         FMT_IA4: begin
            desc.inner = {row_ff[1:0], col_ff[2:0]};
            tile_row   = TCOORD_W'(row_ff >> 2);
            tile_col   = TCOORD_W'(col_ff >> 3);
            tpr_sum    = {1'b0, width_ff} + (SIDE_W + 1)'(7);
         end
         default: begin
            desc.inner = {row_ff[1:0], col_ff[1:0], 1'b0};
            tile_row   = TCOORD_W'(row_ff >> 2);
            tile_col   = TCOORD_W'(col_ff >> 2);
            tpr_sum    = {1'b0, width_ff} + (SIDE_W + 1)'(3);
         end
      endcase
      if (fmt_ff == FMT_I4 || fmt_ff == FMT_IA4) begin
         tiles_per_row = TPR_W'(tpr_sum >> 3);
      end else begin
         tiles_per_row = TPR_W'(tpr_sum >> 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_RGB565;
         width_ff  <= clamp_side(TTFC_SIDE_RESET);
         height_ff <= clamp_side(TTFC_SIDE_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         fmt_ff    <= fmt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

`include "texture_tile_format_converter_top_assert.svh"

   // the image's final pixel brings both counters home
   `TTFC_ASSERT_NEXT(a_front_wrap, clock, reset, accept && img_end, {col_ff, row_ff} == '0)

endmodule

`default_nettype wire

// ===== rtl/ttfc_queue.sv =====
// short queue between the classifying front end and the write back end
// depends on ttfc_pkg for its depth
`default_nettype none

module ttfc_queue
   import ttfc_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] wdata,
   output logic             full,
   output logic             valid,
   input  wire              pop,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = $clog2(TTFC_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(TTFC_QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [TTFC_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == CNT_W'(TTFC_QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign rdata = entry_ff[rd_ptr_ff];

   // pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(TTFC_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(TTFC_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

`include "texture_tile_format_converter_top_assert.svh"

   `TTFC_ASSERT_HOLDS(a_queue_no_overflow, clock, reset, push, !full || pop)
   `TTFC_ASSERT_HOLDS(a_queue_no_underflow, clock, reset, pop, valid)

endmodule

`default_nettype wire

// ===== rtl/ttfc_back.sv =====
// back end: tile address multiply, texel packing and the output register
// depends on ttfc_pkg
`default_nettype none

module ttfc_back
   import ttfc_pkg::*;
#(
   parameter int MAX_SIDE = TTFC_MAX_SIDE,
   localparam int TCOORD_W = $clog2((MAX_SIDE - 1) / 4 + 1),
   localparam int TPR_W    = $clog2((MAX_SIDE + 3) / 4 + 1)
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   output logic                q_pop,
   input  desc_type            desc,
   input  wire  [TCOORD_W-1:0] tile_row,
   input  wire  [TCOORD_W-1:0] tile_col,
   input  wire  [TPR_W-1:0]    tiles_per_row,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output rsp_type             rsp_data
);

   localparam int PROD_W = TCOORD_W + TPR_W;
   localparam int TILE_W = PROD_W + 1;
   localparam int FULL_W = TILE_W + TTFC_INNER_W;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              take;
   logic [PROD_W-1:0] prod;
   logic [TILE_W-1:0] tile;
   logic [FULL_W-1:0] offset_full;
   logic [FULL_W+TTFC_OFFSET_W-1:0] offset_ext;
   logic [15:0]       data;
   part_type          part;
   logic [7:0]        r, g, b, a;

   assign take  = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop = take;

   // tile index and byte offset, wrapped to the offset width
   assign prod        = {{TPR_W{1'b0}}, tile_row} * {{TCOORD_W{1'b0}}, tiles_per_row};
   assign tile        = {1'b0, prod} + {{(TPR_W + 1){1'b0}}, tile_col};
   assign offset_full = {tile, desc.inner};
   assign offset_ext  = {{TTFC_OFFSET_W{1'b0}}, offset_full};

   assign r = desc.pixel.red;
   assign g = desc.pixel.green;
   assign b = desc.pixel.blue;
   assign a = desc.pixel.alpha;

   // texel packing per format
   always_comb begin
      case (desc.fmt)
         FMT_I4: begin
            if (desc.odd_column) begin
               data = {12'b0, a[7:4]};
               part = PART_LOW_NIBBLE;
            end else begin
               data = {8'b0, a[7:4], 4'b0};
               part = PART_HIGH_NIBBLE;
            end
         end
         FMT_IA4: begin
            data = {8'b0, a[7:4], r[7:4]};
            part = PART_BYTE;
         end
         FMT_RGB565: begin
            data = {r[7:3], g[7:2], b[7:3]};
            part = PART_WORD;
         end
         default: begin
            data = {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
            part = PART_WORD;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in        = 1'b1;
         rsp_in.byte_offset  = offset_ext[TTFC_OFFSET_W-1:0];
         rsp_in.write_data   = data;
         rsp_in.write_part   = 2'(part);
         rsp_in.last_pixel   = desc.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "texture_tile_format_converter_top_assert.svh"

   // a popped item always lands in the output register
   `TTFC_ASSERT_NEXT(a_back_take_shows, clock, reset, take, rsp_valid_ff)

endmodule

`default_nettype wire

// ===== rtl/texture_tile_format_converter_top.sv =====
// top level of the tiled texture converter: front end, queue and back end
// depends on ttfc_pkg, ttfc_front, ttfc_queue and ttfc_back
`default_nettype none

// Converts RGBA8 pixels arriving in raster order into tiled-texture writes
// (I4, IA4, RGB565 or RGB5A3), one write per pixel. The block sustains one
// item per clock while the output is taken: the front end classifies a pixel
// and updates the column and row counters in the cycle it is accepted, a
// two-entry queue holds it, and the back end does the tile-index multiply
// and texel packing into the output register, so a result passes through
// the queue and then the output register before it is offered. A stalled
// output only backs up the input once the output register and both queue
// entries are occupied. Configuration writes take effect for the next
// accepted pixel; there is no clearing pass after reset.
module texture_tile_format_converter_top
   import ttfc_pkg::*;
#(
   parameter int MAX_SIDE = TTFC_MAX_SIDE
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_write_en,
   input  wire  [TTFC_CSR_IDX_W-1:0] csr_index,
   input  wire  [TTFC_CSR_W-1:0]     csr_write_data,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output rsp_type                   rsp_data
);

   localparam int TCOORD_W = $clog2((MAX_SIDE - 1) / 4 + 1);
   localparam int TPR_W    = $clog2((MAX_SIDE + 3) / 4 + 1);
   localparam int QW       = $bits(desc_type) + 2 * TCOORD_W + TPR_W;

   logic                q_push, q_pop, q_full, q_valid;
   logic [QW-1:0]       q_wdata, q_rdata;
   desc_type            f_desc, b_desc;
   logic [TCOORD_W-1:0] f_row, f_col, b_row, b_col;
   logic [TPR_W-1:0]    f_tpr, b_tpr;

   ttfc_front #(
      .MAX_SIDE(MAX_SIDE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .desc           (f_desc),
      .tile_row       (f_row),
      .tile_col       (f_col),
      .tiles_per_row  (f_tpr)
   );

   // queue entry layout
   assign q_wdata = {f_desc, f_row, f_col, f_tpr};
   assign {b_desc, b_row, b_col, b_tpr} = q_rdata;

   ttfc_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .valid (q_valid),
      .pop   (q_pop),
      .rdata (q_rdata)
   );

   ttfc_back #(
      .MAX_SIDE(MAX_SIDE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .desc          (b_desc),
      .tile_row      (b_row),
      .tile_col      (b_col),
      .tiles_per_row (b_tpr),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

`default_nettype wire
